// ===== rtl/bresenham_line_rasterizer_macros.svh =====
// assertion helpers for the line rasterizer
// the clock is clk and the reset arst_n in every module that uses them
`ifndef BRESENHAM_LINE_RASTERIZER_MACROS_SVH
`define BRESENHAM_LINE_RASTERIZER_MACROS_SVH

`ifndef SYNTHESIS
`define BRL_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");
`define BRL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");
`else
`define BRL_ASSERT_IMPL(lbl, ante, cons)
`define BRL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/brl_pkg.sv =====
`default_nettype none

package brl_pkg;

	localparam int COORD_BITS = 12;
	localparam int DELTA_BITS = COORD_BITS + 1;
	localparam int ERR_BITS = COORD_BITS + 2;
	localparam int CFG_BITS = 12;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CMP_BITS = COORD_BITS + CFG_BITS;
	localparam int IN_FIELD_BITS = 4 * COORD_BITS;
	localparam int IN_DATA_BITS = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_FIELD_BITS = 2 * COORD_BITS;
	localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_USER_BITS = 2;

	localparam logic [CFG_BITS-1:0] IMAGE_SIZE_RESET = CFG_BITS'(512);

	typedef enum logic {
		OP_START = 1'b0,
		OP_NEXT  = 1'b1
	} op_t;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_IMAGE_COLS = 2'd0,
		REG_IMAGE_ROWS = 2'd1
	} reg_index_t;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic [DELTA_BITS-1:0] delta_t;
	typedef logic signed [ERR_BITS-1:0] err_t;

	// line setup handed from the setup stage to the step stage
	typedef struct packed {
		logic   start;
		logic   steep;
		logic   step_down;
		coord_t major;
		coord_t minor;
		coord_t major_end;
		delta_t delta_major;
		delta_t delta_minor;
	} setup_t;

endpackage

`default_nettype wire

// ===== rtl/brl_setup.sv =====
`default_nettype none

module brl_setup (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            load,
	input  wire logic            valid_s1,
	input  wire logic            op_s1,
	input  wire brl_pkg::coord_t x_start_s1,
	input  wire brl_pkg::coord_t y_start_s1,
	input  wire brl_pkg::coord_t x_end_s1,
	input  wire brl_pkg::coord_t y_end_s1,
	output logic                 valid_s2,
	output brl_pkg::setup_t      setup_s2
);
	import brl_pkg::*;

	logic signed [DELTA_BITS-1:0] drow, dcol, dminor;
	delta_t  adrow, adcol;
	logic    steep, swap;
	coord_t  a0, b0, a1, b1;
	coord_t  major0, minor0, major1, minor1;
	setup_t  setup_d;

	always_comb begin
		drow = DELTA_BITS'(y_end_s1) - DELTA_BITS'(y_start_s1);
		dcol = DELTA_BITS'(x_end_s1) - DELTA_BITS'(x_start_s1);
		adrow = drow[DELTA_BITS-1] ? delta_t'(-drow) : delta_t'(drow);
		adcol = dcol[DELTA_BITS-1] ? delta_t'(-dcol) : delta_t'(dcol);
		steep = adrow > adcol;

		if (steep) begin
			a0 = y_start_s1;
			b0 = x_start_s1;
			a1 = y_end_s1;
			b1 = x_end_s1;
		end else begin
			a0 = x_start_s1;
			b0 = y_start_s1;
			a1 = x_end_s1;
			b1 = y_end_s1;
		end

		// order the endpoints so the major coordinate rises
		swap = a0 > a1;
		major0 = swap ? a1 : a0;
		minor0 = swap ? b1 : b0;
		major1 = swap ? a0 : a1;
		minor1 = swap ? b0 : b1;

		dminor = DELTA_BITS'(minor1) - DELTA_BITS'(minor0);

		setup_d.start       = (op_t'(op_s1) == OP_START);
		setup_d.steep       = steep;
		setup_d.step_down   = !(minor0 < minor1);
		setup_d.major       = major0;
		setup_d.minor       = minor0;
		setup_d.major_end   = major1;
		setup_d.delta_major = delta_t'(DELTA_BITS'(major1) - DELTA_BITS'(major0));
		setup_d.delta_minor = dminor[DELTA_BITS-1] ? delta_t'(-dminor) : delta_t'(dminor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && valid_s1) begin
			setup_s2 <= setup_d;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/brl_step.sv =====
`default_nettype none

module brl_step (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  valid_s2,
	input  wire brl_pkg::setup_t                       setup_s2,
	input  wire logic [brl_pkg::CFG_BITS-1:0]          image_cols,
	input  wire logic [brl_pkg::CFG_BITS-1:0]          image_rows,
	output logic                                       ready_s2,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [brl_pkg::OUT_DATA_BITS-1:0]          out_data,
	output logic [brl_pkg::OUT_USER_BITS-1:0]          out_user,
	output logic                                       out_last
);
	import brl_pkg::*;

	coord_t major_pos_q, minor_pos_q, major_end_q;
	err_t   doubled_error_q;
	delta_t delta_major_q, delta_minor_q;
	logic   minor_step_down_q, steep_flag_q, line_active_q;

	logic   fire, active;
	coord_t cur_major, cur_minor, cur_end;
	err_t   cur_err;
	delta_t cur_dmaj, cur_dmin;
	logic   cur_down, cur_steep;
	coord_t row, col;
	logic   vis, last;
	logic signed [ERR_BITS:0] err_sub, err_add;

	logic   out_vld_s3;
	coord_t row_s3, col_s3;
	logic   pix_s3, vis_s3, last_s3;

	assign ready_s2 = !out_vld_s3 || out_ready;
	assign fire = valid_s2 && ready_s2;

	always_comb begin
		if (setup_s2.start) begin
			cur_major = setup_s2.major;
			cur_minor = setup_s2.minor;
			cur_end   = setup_s2.major_end;
			cur_dmaj  = setup_s2.delta_major;
			cur_dmin  = setup_s2.delta_minor;
			cur_err   = ERR_BITS'(setup_s2.delta_major);
			cur_down  = setup_s2.step_down;
			cur_steep = setup_s2.steep;
		end else begin
			cur_major = major_pos_q;
			cur_minor = minor_pos_q;
			cur_end   = major_end_q;
			cur_dmaj  = delta_major_q;
			cur_dmin  = delta_minor_q;
			cur_err   = doubled_error_q;
			cur_down  = minor_step_down_q;
			cur_steep = steep_flag_q;
		end
		active = setup_s2.start || line_active_q;

		row = cur_steep ? cur_major : cur_minor;
		col = cur_steep ? cur_minor : cur_major;
		vis = !col[COORD_BITS-1] && (CMP_BITS'({1'b0, col}) < CMP_BITS'(image_cols)) &&
		      !row[COORD_BITS-1] && (CMP_BITS'({1'b0, row}) < CMP_BITS'(image_rows));
		last = cur_major >= cur_end;

		// doubled error term, one subtract and a conditional add back
		err_sub = (ERR_BITS+1)'(cur_err) - (ERR_BITS+1)'({cur_dmin, 1'b0});
		err_add = err_sub + (ERR_BITS+1)'({cur_dmaj, 1'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q       <= '0;
			minor_pos_q       <= '0;
			major_end_q       <= '0;
			doubled_error_q   <= '0;
			delta_major_q     <= '0;
			delta_minor_q     <= '0;
			minor_step_down_q <= 1'b0;
			steep_flag_q      <= 1'b0;
			line_active_q     <= 1'b0;
		end else if (fire && active) begin
			major_end_q       <= cur_end;
			delta_major_q     <= cur_dmaj;
			delta_minor_q     <= cur_dmin;
			minor_step_down_q <= cur_down;
			steep_flag_q      <= cur_steep;
			if (last) begin
				line_active_q   <= 1'b0;
				major_pos_q     <= cur_major;
				minor_pos_q     <= cur_minor;
				doubled_error_q <= cur_err;
			end else begin
				line_active_q <= 1'b1;
				major_pos_q   <= cur_major + coord_t'(1);
				if (err_sub[ERR_BITS]) begin
					minor_pos_q     <= cur_down ? cur_minor - coord_t'(1)
					                            : cur_minor + coord_t'(1);
					doubled_error_q <= err_t'(err_add);
				end else begin
					minor_pos_q     <= cur_minor;
					doubled_error_q <= err_t'(err_sub);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s3 <= 1'b0;
		end else if (ready_s2) begin
			out_vld_s3 <= valid_s2;
		end
	end

	// no active line gives an all-zero result
	always_ff @(posedge clk) begin
		if (fire) begin
			pix_s3  <= active;
			vis_s3  <= active && vis;
			last_s3 <= active && last;
			row_s3  <= active ? row : '0;
			col_s3  <= active ? col : '0;
		end
	end

	assign out_valid = out_vld_s3;
	assign out_data  = OUT_DATA_BITS'({col_s3, row_s3});
	assign out_user  = {vis_s3, pix_s3};
	assign out_last  = last_s3;

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_rasterizer.sv =====
// each input transaction passes through the input, setup and step registers to its result
// throughput: one item per cycle unless m_axis_tready stalls; the step stage's error
// and position update closes on itself, so a pixel depends only on the one before it
// reset: arst_n asynchronous active low; clears the pipeline, drops any line in
// progress and sets image_cols and image_rows to 512
`default_nettype none
`include "bresenham_line_rasterizer_macros.svh"

module bresenham_line_rasterizer (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [brl_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [brl_pkg::CFG_BITS-1:0]          cfg_data,
	input  wire logic                                  s_axis_tvalid,
	output logic                                       s_axis_tready,
	// x_start, y_start, x_end, y_end
	input  wire logic [brl_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
	// operation
	input  wire logic [0:0]                            s_axis_tuser,
	output logic                                       m_axis_tvalid,
	input  wire logic                                  m_axis_tready,
	// pixel_row, pixel_col
	output logic [brl_pkg::OUT_DATA_BITS-1:0]          m_axis_tdata,
	// pixel_valid, visible
	output logic [brl_pkg::OUT_USER_BITS-1:0]          m_axis_tuser,
	output logic                                       m_axis_tlast
);
	import brl_pkg::*;

	logic [CFG_BITS-1:0] image_cols_q, image_rows_q;

	logic   valid_s1, op_s1;
	coord_t x_start_s1, y_start_s1, x_end_s1, y_end_s1;
	logic   valid_s2, ready_s2, load_s2;
	setup_t setup_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q <= IMAGE_SIZE_RESET;
			image_rows_q <= IMAGE_SIZE_RESET;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_IMAGE_COLS: image_cols_q <= cfg_data;
				REG_IMAGE_ROWS: image_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// setup stage loads when empty or when it hands on to the step stage
	assign load_s2 = !valid_s2 || ready_s2;
	assign s_axis_tready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			op_s1      <= s_axis_tuser[0];
			x_start_s1 <= coord_t'(s_axis_tdata[COORD_BITS-1:0]);
			y_start_s1 <= coord_t'(s_axis_tdata[2*COORD_BITS-1:COORD_BITS]);
			x_end_s1   <= coord_t'(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]);
			y_end_s1   <= coord_t'(s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]);
		end
	end

	brl_setup u_setup (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load_s2),
		.valid_s1   (valid_s1),
		.op_s1      (op_s1),
		.x_start_s1 (x_start_s1),
		.y_start_s1 (y_start_s1),
		.x_end_s1   (x_end_s1),
		.y_end_s1   (y_end_s1),
		.valid_s2   (valid_s2),
		.setup_s2   (setup_s2)
	);

	brl_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s2   (valid_s2),
		.setup_s2   (setup_s2),
		.image_cols (image_cols_q),
		.image_rows (image_rows_q),
		.ready_s2   (ready_s2),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_data   (m_axis_tdata),
		.out_user   (m_axis_tuser),
		.out_last   (m_axis_tlast)
	);

	`BRL_ASSERT_IMPL(a_idle_takes_input, !valid_s1, s_axis_tready)
	`BRL_ASSERT_IMPL(a_last_has_pixel, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])
	`BRL_ASSERT_IMPL(a_visible_has_pixel, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])
	`BRL_ASSERT_IMPL(a_no_pixel_is_zero, m_axis_tvalid && !m_axis_tuser[0], m_axis_tdata == '0)

endmodule

`default_nettype wire
